// ===== rtl/dspid_pkg.sv =====
// Package for the dual-sensor PID steering block.
// Holds the transaction types, field widths, register codes and reset constants.
package dspid_pkg;

    typedef struct packed {
        logic        sensor_select;
        logic [15:0] clear_level;
    } t_in;

    typedef struct packed {
        logic signed [31:0] forward_speed;
        logic signed [31:0] lateral_speed;
        logic signed [31:0] turn_rate;
    } t_out;

    localparam int GAIN_W = 24;
    localparam int ERR_W  = 18;
    localparam int DIFF_W = 19;
    localparam int INT_W  = 32;
    localparam int ACC_W  = 60;
    localparam int MAG_W  = 32;
    localparam int QUO_W  = 16;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_OFFSET = 3'd1,
        REG_GAIN_P = 3'd2,
        REG_GAIN_I = 3'd3,
        REG_GAIN_D = 3'd4
    } t_reg_idx;

    localparam logic [15:0] RST_TARGET = 16'd600;
    localparam logic [15:0] RST_OFFSET = 16'd80;
    localparam logic [23:0] RST_GAIN_P = 24'd8389;
    localparam logic [23:0] RST_GAIN_I = 24'd105;
    localparam logic [23:0] RST_GAIN_D = 24'd10486;

    // 0.035 in Q0.20
    localparam logic [15:0] LAT_GAIN = 16'd36700;

endpackage

// ===== rtl/dspid_mac.sv =====
// Bit-serial multiply-accumulate for the PID sum, one gain bit per cycle, MSB first.
// Depends on dspid_pkg.
module dspid_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [dspid_pkg::ERR_W-1:0]  i_err,
    input  logic signed [dspid_pkg::INT_W-1:0]  i_integ,
    input  logic signed [dspid_pkg::DIFF_W-1:0] i_diff,
    input  logic        [dspid_pkg::GAIN_W-1:0] i_gain_p,
    input  logic        [dspid_pkg::GAIN_W-1:0] i_gain_i,
    input  logic        [dspid_pkg::GAIN_W-1:0] i_gain_d,
    output logic                                o_busy,
    output logic signed [dspid_pkg::ACC_W-1:0]  o_acc
);
    import dspid_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam int ADD_W = INT_W + 4;

    logic                     r_busy;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [INT_W-1:0]  r_integ;
    logic signed [DIFF_W-1:0] r_diff;
    logic [GAIN_W-1:0]        r_gp;
    logic [GAIN_W-1:0]        r_gi;
    logic [GAIN_W-1:0]        r_gd;
    logic signed [ADD_W-1:0]  w_add;
    logic signed [ACC_W-1:0]  n_acc;

    always_comb begin
        w_add = (r_gp[GAIN_W-1] ? ADD_W'(r_err)   : '0)
              + (r_gi[GAIN_W-1] ? ADD_W'(r_integ) : '0)
              + (r_gd[GAIN_W-1] ? ADD_W'(r_diff)  : '0);
        n_acc = (r_acc <<< 1) + ACC_W'(w_add);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_err   <= i_err;
            r_integ <= i_integ;
            r_diff  <= i_diff;
            r_gp    <= i_gain_p;
            r_gi    <= i_gain_i;
            r_gd    <= i_gain_d;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_gp  <= r_gp << 1;
            r_gi  <= r_gi << 1;
            r_gd  <= r_gd << 1;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;

endmodule

// ===== rtl/dspid_div.sv =====
// Restoring divider, one quotient bit per cycle, for the forward speed
// round(3*2^31 / (2^17 + |turn|)). Depends on dspid_pkg.
module dspid_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [dspid_pkg::MAG_W-1:0]        i_mag,
    output logic                               o_busy,
    output logic [dspid_pkg::QUO_W-1:0]        o_quo
);
    import dspid_pkg::*;

    localparam int DEN_W = MAG_W + 1;
    localparam int DIV_W = DEN_W + 1;
    localparam int NUM_W = DEN_W + 2;
    localparam int CNT_W = $clog2(QUO_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_low;
    logic [DEN_W-1:0]     w_den;
    logic [NUM_W-1:0]     w_num;
    logic [DIV_W:0]       w_t;
    logic                 w_ge;

    always_comb begin
        w_den = DEN_W'(i_mag) + DEN_W'(33'h2_0000);
        w_num = (NUM_W'(3) << 32) + NUM_W'(w_den);
        w_t   = {r_rem, r_low[QUO_W-1]};
        w_ge  = w_t >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_div  <= {w_den, 1'b0};
            r_rem  <= DIV_W'(w_num[NUM_W-1:QUO_W]);
            r_low  <= w_num[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_W'(w_t - {1'b0, r_div}) : w_t[DIV_W-1:0];
            r_low <= {r_low[QUO_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_low;

endmodule

// ===== rtl/dual_sensor_pid_steering_top.sv =====
// Top level of the dual-sensor PID steering block: APB registers, sequencer, output stage.
// Depends on dspid_pkg, dspid_mac and dspid_div.
//
// Each accepted reading updates its sensor's PID loop; a combined speed command is
// produced when the other sensor has reported since its flag was last cleared, which
// clears that flag; sensor 1 counts as reported after reset. A reading goes through
// S_ERR, S_MAC and S_TURN and, if it gives a command, S_LAT1, S_LAT2, S_SUM and S_OUT
// before the next is accepted. The PID sum runs on a serial multiply-accumulate, one
// gain bit at a time, and the forward speed on a restoring divider, one quotient bit at
// a time. A command that finds the output register still full waits until that
// transaction is taken. The input takes a new transaction only when the sequencer is
// idle; the output register holds a finished command while the next reading is worked on.
module dual_sensor_pid_steering_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dspid_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dspid_pkg::t_out   o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dspid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ERR, S_MAC, S_TURN, S_LAT1, S_LAT2, S_SUM, S_OUT
    } t_state;

    localparam int PROD_W = 51;
    localparam int V_W    = 56;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] round20(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + PROD_W'(524288)) >>> 20;
        return t[31:0];
    endfunction

    logic [15:0]              r_target;
    logic [15:0]              r_offset;
    logic [GAIN_W-1:0]        r_gp;
    logic [GAIN_W-1:0]        r_gi;
    logic [GAIN_W-1:0]        r_gd;

    t_state                   r_state;
    logic                     r_sel;
    logic [15:0]              r_level;
    logic signed [INT_W-1:0]  r_integ1;
    logic signed [INT_W-1:0]  r_integ2;
    logic signed [ERR_W-1:0]  r_last1;
    logic signed [ERR_W-1:0]  r_last2;
    logic signed [31:0]       r_turn1;
    logic signed [31:0]       r_turn2;
    logic                     r_seen1;
    logic                     r_seen2;
    logic signed [V_W-1:0]    r_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [31:0]       r_lat1;
    logic signed [31:0]       r_lat_sum;
    logic signed [31:0]       r_trn;
    t_out                     r_out;
    logic                     r_out_valid;

    logic signed [ERR_W-1:0]  w_err;
    logic signed [INT_W-1:0]  w_integ_old;
    logic signed [INT_W-1:0]  w_integ_new;
    logic signed [ERR_W-1:0]  w_last;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [32:0]       w_mul_a;
    logic signed [17:0]       w_lgain;
    logic signed [PROD_W-1:0] w_prod;
    logic [MAG_W-1:0]         w_mag;
    logic                     w_cfg_wr;
    logic                     w_out_load;

    logic                     mac_busy;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     div_busy;
    logic [QUO_W-1:0]         div_quo;

    always_comb begin
        w_err = $signed({2'b00, r_level}) - $signed({2'b00, r_target})
              + (r_sel ? $signed({2'b00, r_offset}) : 18'sd0);
        w_integ_old = r_sel ? r_integ2 : r_integ1;
        w_integ_new = sat32(64'(w_integ_old) + 64'(w_err));
        w_last      = r_sel ? r_last2 : r_last1;
        w_diff      = DIFF_W'(w_err) - DIFF_W'(w_last);
        w_mul_a     = (r_state == S_LAT1) ? 33'(r_turn1) : -33'(r_turn2);
        w_lgain     = $signed({2'b00, LAT_GAIN});
        w_prod      = PROD_W'(w_mul_a) * PROD_W'(w_lgain);
        w_mag       = r_turn1[31] ? MAG_W'(-33'(r_turn1)) : MAG_W'(r_turn1);
        w_out_load  = (r_state == S_OUT) && !div_busy && (!r_out_valid || i_out_ready);
    end

    dspid_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_ERR),
        .i_err    (w_err),
        .i_integ  (w_integ_new),
        .i_diff   (w_diff),
        .i_gain_p (r_gp),
        .i_gain_i (r_gi),
        .i_gain_d (r_gd),
        .o_busy   (mac_busy),
        .o_acc    (mac_acc)
    );

    dspid_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LAT1),
        .i_mag   (w_mag),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= RST_TARGET;
            r_offset <= RST_OFFSET;
            r_gp     <= RST_GAIN_P;
            r_gi     <= RST_GAIN_I;
            r_gd     <= RST_GAIN_D;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_TARGET: r_target <= pwdata[15:0];
                REG_OFFSET: r_offset <= pwdata[15:0];
                REG_GAIN_P: r_gp     <= pwdata[GAIN_W-1:0];
                REG_GAIN_I: r_gi     <= pwdata[GAIN_W-1:0];
                REG_GAIN_D: r_gd     <= pwdata[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TARGET: prdata = 32'(r_target);
            REG_OFFSET: prdata = 32'(r_offset);
            REG_GAIN_P: prdata = 32'(r_gp);
            REG_GAIN_I: prdata = 32'(r_gi);
            REG_GAIN_D: prdata = 32'(r_gd);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ1    <= '0;
            r_integ2    <= '0;
            r_last1     <= '0;
            r_last2     <= '0;
            r_turn1     <= '0;
            r_turn2     <= '0;
            r_seen1     <= 1'b1;
            r_seen2     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sel   <= i_in_data.sensor_select;
                        r_level <= i_in_data.clear_level;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    if (r_sel) begin
                        r_integ2 <= w_integ_new;
                        r_last2  <= w_err;
                    end else begin
                        r_integ1 <= w_integ_new;
                        r_last1  <= w_err;
                    end
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (!mac_busy) begin
                        r_v     <= V_W'((mac_acc + ACC_W'(8)) >>> 4);
                        r_state <= S_TURN;
                    end
                end
                S_TURN: begin
                    r_state <= S_IDLE;
                    if (r_sel) begin
                        r_turn2 <= sat32(-64'(r_v));
                        r_seen2 <= 1'b1;
                        if (r_seen1) begin
                            r_seen1 <= 1'b0;
                            r_state <= S_LAT1;
                        end
                    end else begin
                        r_turn1 <= sat32(64'(r_v));
                        r_seen1 <= 1'b1;
                        if (r_seen2) begin
                            r_seen2 <= 1'b0;
                            r_state <= S_LAT1;
                        end
                    end
                end
                S_LAT1: begin
                    r_prod  <= w_prod;
                    r_state <= S_LAT2;
                end
                S_LAT2: begin
                    r_lat1  <= round20(r_prod);
                    r_prod  <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_lat_sum <= sat32(64'(r_lat1) + 64'(round20(r_prod)));
                    r_trn     <= sat32(64'(r_turn1) + 64'(r_turn2));
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out.forward_speed <= $signed(32'(div_quo));
                        r_out.lateral_speed <= r_lat_sum;
                        r_out.turn_rate     <= r_trn;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for dual_sensor_pid_steering_top.
// Depends on dspid_pkg; predicts speed commands from sensor readings and APB register writes.
module tb;
    import dspid_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dual_sensor_pid_steering_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // predictor copy of registers and loop state
    logic [15:0]        m_target;
    logic [15:0]        m_offset;
    logic [23:0]        m_gain_p;
    logic [23:0]        m_gain_i;
    logic [23:0]        m_gain_d;
    longint             m_integ [2];
    longint             m_last_err [2];
    longint             m_turn [2];
    bit                 m_seen [2];

    t_in    reading_q [$];
    t_out   command_q [$];
    int     errors;
    int     cycle;
    bit     hold_off_req;
    int     in_accepted;
    int     in_queued;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_shift(longint v, int s);
        longint x;
        x = v + (longint'(1) << (s - 1));
        return x >>> s;
    endfunction

    task automatic predict_reading(t_in r);
        int     k;
        longint e;
        longint acc;
        longint v;
        longint mag;
        longint den;
        longint fwd;
        longint lat;
        longint trn;
        t_out   c;
        k = r.sensor_select;
        if (k == 0) e = longint'(r.clear_level) - longint'(m_target);
        else e = longint'(r.clear_level) - (longint'(m_target) - longint'(m_offset));
        m_integ[k] = clamp32(m_integ[k] + e);
        acc = e * longint'(m_gain_p) + m_integ[k] * longint'(m_gain_i)
            + (e - m_last_err[k]) * longint'(m_gain_d);
        m_last_err[k] = e;
        v = floor_shift(acc, 4);
        m_turn[k] = (k == 0) ? clamp32(v) : clamp32(-v);
        m_seen[k] = 1;
        if (m_seen[1 - k]) begin
            m_seen[1 - k] = 0;
            mag = (m_turn[0] < 0) ? -m_turn[0] : m_turn[0];
            den = (longint'(1) << 17) + mag;
            fwd = (2 * (longint'(3) << 31) + den) / (2 * den);
            lat = clamp32(floor_shift(m_turn[0] * 36700, 20)
                + floor_shift(-m_turn[1] * 36700, 20));
            trn = clamp32(m_turn[0] + m_turn[1]);
            c.forward_speed = fwd[31:0];
            c.lateral_speed = lat[31:0];
            c.turn_rate = trn[31:0];
            command_q.push_back(c);
        end
    endtask

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle <= cycle + 1;

    always @(posedge clk) begin
        if (cycle > 1500000) begin
            $display("FAIL dual_sensor_pid_steering_top");
            $finish;
        end
    end

    // driver
    int in_gap;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_gap <= 0;
        end else if (in_valid && in_ready) begin
            predict_reading(in_data);
            in_accepted <= in_accepted + 1;
            in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (in_gap == 0 && reading_q.size() > 0) begin
                in_data <= reading_q.pop_front();
            end else begin
                in_valid <= 0;
            end
        end else if (!in_valid) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (reading_q.size() > 0) begin
                in_valid <= 1;
                in_data <= reading_q.pop_front();
            end
        end
    end

    // monitor
    int out_gap;
    int hold_cnt;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 0;
            out_gap <= 0;
            hold_cnt <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (command_q.size() == 0) begin
                    $error("unexpected command %h", out_data);
                    errors++;
                end else begin
                    t_out x;
                    x = command_q.pop_front();
                    if (x.forward_speed !== out_data.forward_speed) begin
                        $error("forward_speed exp %0d got %0d", x.forward_speed,
                            out_data.forward_speed);
                        errors++;
                    end
                    if (x.lateral_speed !== out_data.lateral_speed) begin
                        $error("lateral_speed exp %0d got %0d", x.lateral_speed,
                            out_data.lateral_speed);
                        errors++;
                    end
                    if (x.turn_rate !== out_data.turn_rate) begin
                        $error("turn_rate exp %0d got %0d", x.turn_rate, out_data.turn_rate);
                        errors++;
                    end
                end
            end
            if (hold_off_req && hold_cnt == 0) begin
                hold_cnt <= 3000;
                out_ready <= 0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                out_ready <= (hold_cnt == 1);
            end else if (out_valid && out_ready) begin
                out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
                out_ready <= (out_gap == 0);
            end else if (!out_ready) begin
                if (out_gap > 0) out_gap <= out_gap - 1;
                else out_ready <= 1;
            end
        end
    end

    task automatic wait_idle();
        while (in_accepted != in_queued || command_q.size() != 0 || in_valid) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_TARGET: m_target = val[15:0];
            REG_OFFSET: m_offset = val[15:0];
            REG_GAIN_P: m_gain_p = val[23:0];
            REG_GAIN_I: m_gain_i = val[23:0];
            default:    m_gain_d = val[23:0];
        endcase
    endtask

    task automatic add_reading(bit sel, logic [15:0] lvl);
        t_in r;
        r.sensor_select = sel;
        r.clear_level = lvl;
        reading_q.push_back(r);
        in_queued++;
    endtask

    task automatic random_phase(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) add_reading($urandom, 16'($urandom));
            else if ($urandom_range(0, 1) == 0) add_reading($urandom, 16'($urandom_range(0, 1200)));
            else add_reading(i[0] ^ ($urandom_range(0, 7) == 0), 16'($urandom));
        end
    endtask

    initial begin
        int p;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_data = '0;
        errors = 0;
        cycle = 0;
        hold_off_req = 0;
        in_accepted = 0;
        in_queued = 0;
        m_target = RST_TARGET;
        m_offset = RST_OFFSET;
        m_gain_p = RST_GAIN_P;
        m_gain_i = RST_GAIN_I;
        m_gain_d = RST_GAIN_D;
        m_integ = '{0, 0};
        m_last_err = '{0, 0};
        m_turn = '{0, 0};
        m_seen = '{1, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset settings, extremes, same sensor twice
        add_reading(1, 16'd0);
        add_reading(0, 16'hffff);
        add_reading(0, 16'd0);
        add_reading(1, 16'hffff);
        add_reading(1, 16'd520);
        add_reading(0, 16'd600);
        add_reading(1, 16'h5555);
        add_reading(0, 16'haaaa);
        wait_idle();

        // max gains to drive integral and turn into saturation
        reg_write(REG_TARGET, 32'h0000_ffff);
        reg_write(REG_OFFSET, 32'h0000_ffff);
        reg_write(REG_GAIN_P, 32'h00ff_ffff);
        reg_write(REG_GAIN_I, 32'h00ff_ffff);
        reg_write(REG_GAIN_D, 32'h00ff_ffff);
        repeat (6) begin
            add_reading(0, 16'd0);
            add_reading(1, 16'hffff);
        end
        for (p = 0; p < 4; p++) add_reading(p[0], 16'hffff);
        wait_idle();

        reg_write(REG_TARGET, 32'd0);
        reg_write(REG_OFFSET, 32'd0);
        reg_write(REG_GAIN_P, 32'd0);
        reg_write(REG_GAIN_I, 32'd0);
        reg_write(REG_GAIN_D, 32'd0);
        add_reading(0, 16'hffff);
        add_reading(1, 16'hffff);
        wait_idle();

        for (p = 0; p < 8; p++) begin
            reg_write(REG_TARGET, $urandom);
            reg_write(REG_OFFSET, (p < 4) ? $urandom_range(0, 200) : $urandom);
            reg_write(REG_GAIN_P, (p < 5) ? $urandom_range(0, 40000) : $urandom);
            reg_write(REG_GAIN_I, (p < 5) ? $urandom_range(0, 400) : $urandom);
            reg_write(REG_GAIN_D, (p < 5) ? $urandom_range(0, 40000) : $urandom);
            if (p == 2) hold_off_req = 1;
            random_phase(210);
            if (p == 2) begin
                while (command_q.size() == 0) @(posedge clk);
                hold_off_req = 0;
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("PASS dual_sensor_pid_steering_top");
        end else begin
            $display("FAIL dual_sensor_pid_steering_top");
        end
        $finish;
    end
endmodule
